@@ rtl/tempo_ratio_distance_macros.svh @@
// Assertion macros of the checker file of the tempo ratio distance block.
// Depends on nothing; included by the checker file only.
`ifndef TEMPO_RATIO_DISTANCE_MACROS_SVH
`define TEMPO_RATIO_DISTANCE_MACROS_SVH

// Implication checked at every rising edge, switched off while reset is held.
`define TRD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tempo_ratio_distance: assertion failed");

// Condition that must hold at every rising edge outside reset.
`define TRD_ASSERT_ALWAYS(lbl, ck, rn, cond) \
	`TRD_ASSERT_IMP(lbl, ck, rn, 1'b1, cond)

`endif

@@ rtl/trd_pkg.sv @@
// Package of the tempo ratio distance block: widths, register indexes, reset values, types.
// No dependencies; imported by every module of the block.
package trd_pkg;

	localparam int VAL_W      = 32;   // Q16.16 tempo input
	localparam int Q_W        = 24;   // Q8.16 ratio, weight and distance
	localparam int FRAC_W     = 16;   // fraction bits of Q8.16
	localparam int MULT_W     = 8;    // integer multiple
	localparam int ENT_W      = 2;    // entries_in_use register
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int LOW_W      = VAL_W - Q_W;  // dividend bits not in the first remainder

	localparam int MAX_MULTIPLES     = 3;
	localparam int DEF_NUM_MULTIPLES = 3;

	// Input register, one divider stage per quotient bit, then diff, product and minimum.
	localparam int LATENCY = 1 + Q_W + 3;

	localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES     = 3'd0;
	localparam int                   CFG_MULT_BASE   = 1;
	localparam int                   CFG_WEIGHT_BASE = 4;

	localparam logic [ENT_W-1:0] ENTRIES_RESET = 2'd3;
	localparam logic [Q_W-1:0]   WEIGHT_RESET  = 24'h010000;

	// Control that travels beside the payload through the pipeline.
	typedef struct packed {
		logic valid;
		logic zero;
	} trd_ctl_t;

	// Reset value of multiple register i is i + 1.
	function automatic logic [MULT_W-1:0] mult_reset(input int idx);
		return MULT_W'(idx + 1);
	endfunction

endpackage

@@ rtl/trd_divider.sv @@
// Pipelined restoring divider: (big << 16) / small, one quotient bit per stage, saturated to Q8.16.
// Depends on trd_pkg.
module trd_divider import trd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  trd_ctl_t         in_ctl,
	input  logic [VAL_W-1:0] big,
	input  logic [VAL_W-1:0] small_val,
	output trd_ctl_t         out_ctl,
	output logic [Q_W-1:0]   ratio
);

	trd_ctl_t         ctl_s  [Q_W];
	logic [VAL_W-1:0] rem_s  [Q_W];
	logic [VAL_W-1:0] dvs_s  [Q_W];
	logic [Q_W-1:0]   quot_s [Q_W];
	logic [LOW_W-1:0] low_s  [Q_W];
	logic             sat_s  [Q_W];

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		trd_ctl_t         ctl_in;
		logic [VAL_W-1:0] rem_in;
		logic [VAL_W-1:0] dvs_in;
		logic [Q_W-1:0]   quot_in;
		logic [LOW_W-1:0] low_in;
		logic             sat_in;
		logic [VAL_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			// The quotient overflows 24 bits exactly when big >> 8 is not below small.
			assign ctl_in  = in_ctl;
			assign rem_in  = VAL_W'(big[VAL_W-1:LOW_W]);
			assign dvs_in  = small_val;
			assign quot_in = '0;
			assign low_in  = big[LOW_W-1:0];
			assign sat_in  = (rem_in >= small_val);
		end else begin : g_next
			assign ctl_in  = ctl_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign dvs_in  = dvs_s[i-1];
			assign quot_in = quot_s[i-1];
			assign low_in  = low_s[i-1];
			assign sat_in  = sat_s[i-1];
		end

		assign trial = {rem_in, low_in[LOW_W-1]};
		assign ge    = (trial >= {1'b0, dvs_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else begin
				ctl_s[i] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? VAL_W'(trial - {1'b0, dvs_in}) : trial[VAL_W-1:0];
			dvs_s[i]  <= dvs_in;
			quot_s[i] <= {quot_in[Q_W-2:0], ge};
			low_s[i]  <= {low_in[LOW_W-2:0], 1'b0};
			sat_s[i]  <= sat_in;
		end
	end

	assign out_ctl = ctl_s[Q_W-1];
	assign ratio   = sat_s[Q_W-1] ? Q_MAX : quot_s[Q_W-1];

endmodule

@@ rtl/trd_distance.sv @@
// Weighted distance pipeline: |ratio - k|, weight product with saturation, minimum over lanes.
// Depends on trd_pkg.
module trd_distance import trd_pkg::*; #(
	parameter int NUM_MULT = DEF_NUM_MULTIPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  trd_ctl_t          in_ctl,
	input  logic [Q_W-1:0]    ratio,
	input  logic [MULT_W-1:0] multiple [NUM_MULT],
	input  logic [Q_W-1:0]    weight [NUM_MULT],
	input  logic [ENT_W-1:0]  active,
	output logic              done,
	output logic [Q_W-1:0]    distance,
	output logic              zero_input
);

	trd_ctl_t       ctl_s1, ctl_s2, ctl_s3;
	logic [Q_W-1:0] diff_s1 [NUM_MULT];
	logic [Q_W-1:0] prod_s2 [NUM_MULT];
	logic [Q_W-1:0] dist_s3;
	logic [Q_W-1:0] best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	for (genvar i = 0; i < NUM_MULT; i++) begin : g_lane
		logic [Q_W-1:0]   target;
		logic [2*Q_W-1:0] prod;

		assign target = {multiple[i], {FRAC_W{1'b0}}};
		assign prod   = weight[i] * diff_s1[i];

		always_ff @(posedge clk) begin
			diff_s1[i] <= (ratio >= target) ? (ratio - target) : (target - ratio);
			prod_s2[i] <= (|prod[2*Q_W-1:Q_W+FRAC_W]) ? Q_MAX : prod[Q_W+FRAC_W-1:FRAC_W];
		end
	end

	always_comb begin
		best = prod_s2[0];
		for (int i = 1; i < NUM_MULT; i++) begin
			if ((ENT_W'(i) < active) && (prod_s2[i] < best)) begin
				best = prod_s2[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		dist_s3 <= ctl_s2.zero ? '0 : best;
	end

	assign done       = ctl_s3.valid;
	assign distance   = dist_s3;
	assign zero_input = ctl_s3.zero;

endmodule

@@ rtl/tempo_ratio_distance.sv @@
// Top level of the tempo ratio distance block: input ordering, configuration registers, pipeline.
// Depends on trd_pkg, trd_divider and trd_distance.
//
//   Channel        Signals                                     Handshake
//   command in     start, first_value, second_value           beat taken when start && !busy
//   result out     done, distance, zero_input                 one-cycle strobe, no back-pressure
//   configuration  cfg_we, cfg_index, cfg_data                 write when cfg_we is high
//
// A beat is taken in every cycle that start is high; busy is always low, since nothing downstream can stall.
// Each result passes from its command beat through one input register, one divider stage
// per quotient bit (24 stages, set by the bit-serial division), then the difference,
// product and minimum stages. Results come out in command order.
// Reset clears the valid bits of every stage and restores the register defaults; there is
// no clearing pass. Configuration is expected to change only while the pipeline is empty.
module tempo_ratio_distance import trd_pkg::*; #(
	parameter int NUM_MULTIPLES = DEF_NUM_MULTIPLES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VAL_W-1:0]      first_value,
	input  logic [VAL_W-1:0]      second_value,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [Q_W-1:0]        distance,
	output logic                  zero_input
);

	localparam logic [ENT_W-1:0] NUM_LIM = ENT_W'(NUM_MULTIPLES);

	logic [ENT_W-1:0]  entries_q;
	logic [MULT_W-1:0] multiple_q [NUM_MULTIPLES];
	logic [Q_W-1:0]    weight_q [NUM_MULTIPLES];
	logic [ENT_W-1:0]  active;

	trd_ctl_t         ctl_s1;
	logic [VAL_W-1:0] big_s1;
	logic [VAL_W-1:0] small_s1;

	trd_ctl_t       div_ctl;
	logic [Q_W-1:0] div_ratio;

	// The pipeline never stalls, so a new command can be taken in every cycle.
	assign busy = 1'b0;

	// Entry count: zero counts as one, and anything above the lane count is clamped.
	always_comb begin
		if (entries_q == '0) begin
			active = ENT_W'(1);
		end else if (entries_q > NUM_LIM) begin
			active = NUM_LIM;
		end else begin
			active = entries_q;
		end
	end

	// Configuration registers. Writes to indexes past the implemented lanes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (cfg_we && (cfg_index == CFG_ENTRIES)) begin
			entries_q <= cfg_data[ENT_W-1:0];
		end
	end

	for (genvar i = 0; i < NUM_MULTIPLES; i++) begin : g_cfg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				multiple_q[i] <= mult_reset(i);
				weight_q[i]   <= WEIGHT_RESET;
			end else if (cfg_we) begin
				if (cfg_index == CFG_IDX_W'(CFG_MULT_BASE + i)) begin
					multiple_q[i] <= cfg_data[MULT_W-1:0];
				end
				if (cfg_index == CFG_IDX_W'(CFG_WEIGHT_BASE + i)) begin
					weight_q[i] <= cfg_data[Q_W-1:0];
				end
			end
		end
	end

	// Input stage: order the pair so the larger value is the dividend. A zero in either
	// input means the smaller value is zero, which forces a zero distance at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start && !busy;
			ctl_s1.zero  <= (first_value == '0) || (second_value == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (first_value > second_value) begin
			big_s1   <= first_value;
			small_s1 <= second_value;
		end else begin
			big_s1   <= second_value;
			small_s1 <= first_value;
		end
	end

	trd_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (ctl_s1),
		.big       (big_s1),
		.small_val (small_s1),
		.out_ctl   (div_ctl),
		.ratio     (div_ratio)
	);

	trd_distance #(
		.NUM_MULT (NUM_MULTIPLES)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ctl     (div_ctl),
		.ratio      (div_ratio),
		.multiple   (multiple_q),
		.weight     (weight_q),
		.active     (active),
		.done       (done),
		.distance   (distance),
		.zero_input (zero_input)
	);

endmodule

@@ rtl/trd_checker.sv @@
// Port-level checks for the tempo ratio distance block, bound to its top level.
// Depends on trd_pkg and tempo_ratio_distance_macros.svh.
`include "tempo_ratio_distance_macros.svh"

module trd_checker import trd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic [VAL_W-1:0]      first_value,
	input logic [VAL_W-1:0]      second_value,
	input logic                  done,
	input logic [Q_W-1:0]        distance,
	input logic                  zero_input
);

	logic in_zero;

	assign in_zero = (first_value == '0) || (second_value == '0);

	// A result beat only ever follows a command beat by the fixed pipeline latency.
	`TRD_ASSERT_IMP(a_result_latency, clk, arst_n, done, $past(start && !busy, LATENCY))

	// The zero flag reports a zero in the inputs of the matching command.
	`TRD_ASSERT_IMP(a_zero_flag, clk, arst_n, done, zero_input == $past(in_zero, LATENCY))

	// A zero divisor forces the distance to zero.
	`TRD_ASSERT_IMP(a_zero_distance, clk, arst_n, done && zero_input, distance == '0)

	// The pipeline is never busy, so it can take a command in every cycle.
	`TRD_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)

endmodule

bind tempo_ratio_distance trd_checker u_trd_checker (.*);

@@ tb/tempo_ratio_distance_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tempo_ratio_distance: random and directed tempo pairs under many
// register settings, checked against a distance predictor. Needs trd_pkg and the block RTL.
module tempo_ratio_distance_tb;
	import trd_pkg::*;

	localparam int CLK_HALF        = 2;
	localparam int RESET_CYCLES    = 9;
	localparam int NUM_MULT        = DEF_NUM_MULTIPLES;
	localparam int BEATS_PER_PHASE = 120;
	localparam int RAND_PHASES     = 8;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int MAX_REPORTS     = 100;

	// Register index that decodes to no register; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	// What the driver does with the head of its queue: send a tempo pair, write a register,
	// or hold everything until no result is outstanding.
	typedef enum logic [1:0] {
		CMD_PAIR,
		CMD_REG_WRITE,
		CMD_SETTLE
	} command_kind_t;

	typedef struct {
		command_kind_t          kind;
		logic [VAL_W-1:0]       first;
		logic [VAL_W-1:0]       second;
		logic [CFG_IDX_W-1:0]   index;
		logic [CFG_DATA_W-1:0]  data;
	} command_t;

	typedef struct packed {
		logic [Q_W-1:0] distance;
		logic           zero_input;
	} distance_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [VAL_W-1:0]      first_value = '0;
	logic [VAL_W-1:0]      second_value = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  done;
	logic [Q_W-1:0]        distance;
	logic                  zero_input;

	command_t         command_q [$];
	distance_result_t expected_distance_q [$];

	// Register copy kept by the monitor; it follows every write seen on the port.
	logic [ENT_W-1:0]  entries_copy;
	logic [MULT_W-1:0] multiple_copy [MAX_MULTIPLES];
	logic [Q_W-1:0]    weight_copy [MAX_MULTIPLES];

	// Multiples of the setting being built, so random pairs can aim near them.
	logic [MULT_W-1:0] aim_multiple [MAX_MULTIPLES];

	int in_flight = 0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_cycles = 0;
	int mismatch_count = 0;

	tempo_ratio_distance #(
		.NUM_MULTIPLES(NUM_MULT)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.first_value  (first_value),
		.second_value (second_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.distance     (distance),
		.zero_input   (zero_input)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Expected result of one pair under the current register copy. The larger value is
	// divided by the smaller into a saturating Q8.16 ratio; each multiple in use gives a
	// weighted gap to the ratio, saturated to 24 bits, and the smallest gap wins.
	function automatic distance_result_t predict_distance(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [VAL_W-1:0]        larger;
		logic [VAL_W-1:0]        smaller;
		logic [VAL_W+FRAC_W-1:0] quotient;
		logic [Q_W-1:0]          ratio;
		logic [Q_W-1:0]          target;
		logic [Q_W-1:0]          gap;
		logic [Q_W-1:0]          term;
		logic [2*Q_W-1:0]        product;
		int                      used;
		distance_result_t        res;
		larger  = (a > b) ? a : b;
		smaller = (a > b) ? b : a;
		res.zero_input = (smaller == '0);
		res.distance   = '0;
		if (!res.zero_input) begin
			quotient = {larger, {FRAC_W{1'b0}}} / (VAL_W+FRAC_W)'(smaller);
			ratio = (quotient > (VAL_W+FRAC_W)'(Q_MAX)) ? Q_MAX : quotient[Q_W-1:0];
			// A count of zero still uses the first pair; counts beyond the build are clamped.
			used = (entries_copy == '0) ? 1 : int'(entries_copy);
			if (used > NUM_MULT)
				used = NUM_MULT;
			for (int i = 0; i < used; i++) begin
				target  = {multiple_copy[i], {FRAC_W{1'b0}}};
				gap     = (ratio >= target) ? ratio - target : target - ratio;
				product = ((2*Q_W)'(weight_copy[i]) * (2*Q_W)'(gap)) >> FRAC_W;
				term    = (product > (2*Q_W)'(Q_MAX)) ? Q_MAX : product[Q_W-1:0];
				if (i == 0 || term < res.distance)
					res.distance = term;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input string want_s, input string got_s);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: %s mismatch, expected %s, got %s", $time, what, want_s, got_s);
		else if (mismatch_count == MAX_REPORTS + 1)
			$display("%0t ns: further mismatches are counted but not shown", $time);
	endtask

	task automatic push_pair(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
		command_t cmd;
		cmd = '{kind: CMD_PAIR, first: a, second: b, index: '0, data: '0};
		command_q.push_back(cmd);
	endtask

	task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		command_t cmd;
		cmd = '{kind: CMD_REG_WRITE, first: '0, second: '0, index: idx, data: val};
		command_q.push_back(cmd);
	endtask

	task automatic push_settle();
		command_t cmd;
		cmd = '{kind: CMD_SETTLE, first: '0, second: '0, index: '0, data: '0};
		command_q.push_back(cmd);
	endtask

	// Half the time the bits above the register's width carry noise, which must be dropped.
	function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] value,
			input int keep_w);
		logic [CFG_DATA_W-1:0] noise;
		noise = ($urandom_range(0, 1) == 1) ? CFG_DATA_W'($urandom) : '0;
		return ((noise >> keep_w) << keep_w) | value;
	endfunction

	// A new setting: wait for the pipeline to empty, then write every register.
	task automatic set_registers(input logic [ENT_W-1:0] ent,
			input logic [MULT_W-1:0] m0, input logic [MULT_W-1:0] m1,
			input logic [MULT_W-1:0] m2, input logic [Q_W-1:0] w0,
			input logic [Q_W-1:0] w1, input logic [Q_W-1:0] w2);
		logic [MULT_W-1:0] mults [MAX_MULTIPLES];
		logic [Q_W-1:0]    weights [MAX_MULTIPLES];
		mults   = '{m0, m1, m2};
		weights = '{w0, w1, w2};
		push_settle();
		push_write(CFG_ENTRIES, with_noise(CFG_DATA_W'(ent), ENT_W));
		for (int i = 0; i < MAX_MULTIPLES; i++) begin
			push_write(CFG_IDX_W'(CFG_MULT_BASE + i), with_noise(CFG_DATA_W'(mults[i]), MULT_W));
			push_write(CFG_IDX_W'(CFG_WEIGHT_BASE + i), CFG_DATA_W'(weights[i]));
			aim_multiple[i] = mults[i];
		end
	endtask

	// Random pairs. Nearly half aim near a multiple, where the minimum is decided; the rest are
	// zero cases, full-range noise and tiny divisors that drive the ratio into saturation.
	task automatic push_random_pairs(input int count);
		logic [VAL_W-1:0] lo;
		logic [VAL_W-1:0] hi;
		logic [63:0]      wide;
		logic [63:0]      jit;
		int               roll;
		int               k;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			lo = $urandom >> $urandom_range(0, 31);
			if (lo == '0)
				lo = VAL_W'(1);
			if (roll < 45) begin
				k = (roll < 30) ? int'(aim_multiple[$urandom_range(0, MAX_MULTIPLES - 1)])
						: $urandom_range(1, 16);
				wide = 64'(lo) * 64'(k);
				jit = (roll < 8) ? 64'd0 : 64'(lo) >> $urandom_range(1, 24);
				if ($urandom_range(0, 1) == 1)
					wide = wide + jit;
				else if (wide > jit)
					wide = wide - jit;
				if (wide > 64'(32'hFFFF_FFFF))
					wide = 64'(32'hFFFF_FFFF);
				hi = wide[VAL_W-1:0];
			end else if (roll < 52) begin
				hi = ($urandom_range(0, 5) == 0) ? '0 : $urandom;
				lo = '0;
			end else if (roll < 80) begin
				hi = $urandom;
				lo = $urandom;
			end else begin
				lo = $urandom_range(1, 300);
				hi = $urandom >> $urandom_range(0, 24);
			end
			if ($urandom_range(0, 1) == 1)
				push_pair(hi, lo);
			else
				push_pair(lo, hi);
			// Now and then the sender holds off until every result is back.
			if ($urandom_range(0, 99) == 0)
				push_settle();
		end
	endtask

	// Driver. A pair goes out on start and stays until it is taken (start && !busy). Register
	// writes and settle points wait until no result is outstanding, so configuration only
	// changes while the pipeline is empty. The outstanding count is kept here from the
	// handshake signals themselves, so it never depends on the order of processes.
	always @(posedge clk or negedge arst_n) begin : driver_seq
		int       flight_now;
		int       roll;
		logic     drive_start;
		logic     drive_we;
		command_t cmd;
		if (!arst_n) begin
			start        <= 1'b0;
			cfg_we       <= 1'b0;
			first_value  <= '0;
			second_value <= '0;
			cfg_index    <= '0;
			cfg_data     <= '0;
			in_flight    <= 0;
			gap_left     <= 0;
			burst_left   = 0;
		end else begin
			flight_now = in_flight + ((start && !busy) ? 1 : 0) - (done ? 1 : 0);
			in_flight <= flight_now;
			// A beat not yet taken keeps start and its data exactly as they are.
			if (!(start && busy)) begin
				drive_start = 1'b0;
				drive_we    = 1'b0;
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (command_q.size() != 0) begin
					cmd = command_q[0];
					case (cmd.kind)
					CMD_PAIR: begin
						drive_start = 1'b1;
						first_value  <= cmd.first;
						second_value <= cmd.second;
						void'(command_q.pop_front());
						// Gaps: mostly none or short, a few long, and gapless bursts.
						if (burst_left > 0) begin
							burst_left = burst_left - 1;
							gap_left <= 0;
						end else begin
							roll = $urandom_range(0, 99);
							if (roll < 3) begin
								burst_left = $urandom_range(20, 80);
								gap_left <= 0;
							end else if (roll < 55) begin
								gap_left <= 0;
							end else if (roll < 88) begin
								gap_left <= $urandom_range(1, 3);
							end else if (roll < 98) begin
								gap_left <= $urandom_range(4, 12);
							end else begin
								gap_left <= $urandom_range(20, 60);
							end
						end
					end
					CMD_REG_WRITE: begin
						if (flight_now == 0) begin
							drive_we = 1'b1;
							cfg_index <= cmd.index;
							cfg_data  <= cmd.data;
							void'(command_q.pop_front());
						end
					end
					default: begin
						if (flight_now == 0)
							void'(command_q.pop_front());
					end
					endcase
				end
				start  <= drive_start;
				cfg_we <= drive_we;
			end
		end
	end

	// Monitor. Results are checked first against the oldest expectation, then register
	// writes are taken into the copy, and then a beat taken at this edge is predicted.
	always @(posedge clk or negedge arst_n) begin : monitor_seq
		distance_result_t want;
		int               slot;
		if (!arst_n) begin
			entries_copy = ENTRIES_RESET;
			for (int i = 0; i < MAX_MULTIPLES; i++) begin
				multiple_copy[i] = MULT_W'(i + 1);
				weight_copy[i]   = WEIGHT_RESET;
			end
			stall_cycles <= 0;
		end else begin
			if (done) begin
				if (expected_distance_q.size() == 0) begin
					report_mismatch("result order", "no result",
							$sformatf("distance %06h zero_input %0b", distance, zero_input));
				end else begin
					want = expected_distance_q.pop_front();
					if (distance !== want.distance)
						report_mismatch("distance", $sformatf("%06h", want.distance),
								$sformatf("%06h", distance));
					if (zero_input !== want.zero_input)
						report_mismatch("zero_input", $sformatf("%0b", want.zero_input),
								$sformatf("%0b", zero_input));
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_ENTRIES) begin
					entries_copy = cfg_data[ENT_W-1:0];
				end else if (int'(cfg_index) >= CFG_MULT_BASE &&
						int'(cfg_index) < CFG_MULT_BASE + MAX_MULTIPLES) begin
					slot = int'(cfg_index) - CFG_MULT_BASE;
					multiple_copy[slot] = cfg_data[MULT_W-1:0];
				end else if (int'(cfg_index) >= CFG_WEIGHT_BASE &&
						int'(cfg_index) < CFG_WEIGHT_BASE + MAX_MULTIPLES) begin
					slot = int'(cfg_index) - CFG_WEIGHT_BASE;
					weight_copy[slot] = cfg_data[Q_W-1:0];
				end
			end
			if (start && !busy)
				expected_distance_q.push_back(predict_distance(first_value, second_value));
			stall_cycles <= (done || (start && !busy)) ? 0 : stall_cycles + 1;
		end
	end

	// Watchdog: too long without a beat taken or a result seen ends the run.
	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// Stimulus. The whole command list is built at time zero; the driver works it off
	// once reset is released.
	initial begin : stimulus_seq
		int                roll;
		logic [MULT_W-1:0] rm [MAX_MULTIPLES];
		logic [Q_W-1:0]    rw [MAX_MULTIPLES];
		for (int i = 0; i < MAX_MULTIPLES; i++)
			aim_multiple[i] = MULT_W'(i + 1);

		// Reset settings: zero inputs, equal inputs, saturated and exact ratios.
		push_pair(32'h0000_0000, 32'h0000_0000);
		push_pair(32'h0000_0000, 32'hFFFF_FFFF);
		push_pair(32'hFFFF_FFFF, 32'h0000_0000);
		push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_pair(32'h0000_0001, 32'hFFFF_FFFF);
		push_pair(32'hFFFF_FFFF, 32'h0000_0001);
		push_pair(32'h0001_0000, 32'h0001_0000);
		push_pair(32'h0001_0000, 32'h0002_0000);
		push_pair(32'h0003_0000, 32'h0001_0000);
		push_pair(32'h0001_8000, 32'h0001_0000);
		push_pair(32'h0000_0001, 32'h0000_0002);
		push_pair(32'hFFFF_FFFF, 32'h8000_0000);
		push_pair(32'h00FF_FFFF, 32'h0001_0000);
		push_pair(32'h0100_0000, 32'h0001_0000);
		push_pair(32'h00FF_0000, 32'h0001_0000);
		push_pair(32'hAAAA_AAAA, 32'h5555_5555);
		push_random_pairs(BEATS_PER_PHASE);

		// A count of zero still uses one pair; a zero multiple compares with the bare ratio;
		// the largest weight saturates the product. The spare index must be ignored.
		set_registers(2'd0, 8'd0, 8'd255, 8'd7, Q_MAX, 24'h000000, 24'h000000);
		push_write(CFG_SPARE, CFG_DATA_W'($urandom));
		push_pair(32'h0000_0000, 32'h0000_0005);
		push_pair(32'h0000_0007, 32'h0000_0007);
		push_pair(32'hFFFF_FFFF, 32'h0000_0001);
		push_random_pairs(BEATS_PER_PHASE);

		// All three pairs, with the extreme multiples and weights.
		set_registers(2'd3, 8'd255, 8'd1, 8'd128, 24'h000000, Q_MAX, 24'h000001);
		push_random_pairs(BEATS_PER_PHASE);

		// Two pairs in use; the third has weight zero and must not win.
		set_registers(2'd2, 8'd1, 8'd2, 8'd255, 24'h008000, 24'h004000, 24'h000000);
		push_random_pairs(BEATS_PER_PHASE);

		for (int p = 0; p < RAND_PHASES; p++) begin
			for (int i = 0; i < MAX_MULTIPLES; i++) begin
				roll = $urandom_range(0, 99);
				rm[i] = (roll < 50) ? MULT_W'($urandom_range(1, 8))
						: (roll < 92) ? MULT_W'($urandom_range(1, 255)) : '0;
				roll = $urandom_range(0, 99);
				rw[i] = (roll < 40) ? Q_W'($urandom)
						: (roll < 70) ? Q_W'($urandom_range(32'h8000, 32'h20000))
						: (roll < 80) ? '0
						: (roll < 90) ? Q_MAX : Q_W'($urandom_range(1, 255));
			end
			set_registers(ENT_W'($urandom_range(0, 3)), rm[0], rm[1], rm[2], rw[0], rw[1], rw[2]);
			push_random_pairs(BEATS_PER_PHASE);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Sample mid-cycle so that the driver's updates at the edge have settled.
		@(negedge clk);
		while (command_q.size() != 0 || start || in_flight != 0)
			@(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);

		if (expected_distance_q.size() != 0) begin
			mismatch_count += expected_distance_q.size();
			$display("%0t ns: %0d expected results never arrived", $time,
					expected_distance_q.size());
		end
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
